@@ hw/rtl/lf3_pkg.sv @@
`default_nettype none

package lf3_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_W = 13;
  localparam int PIX_W = 8;
  localparam int POS_W = 12;
  localparam int VAL_W = 12;
  localparam int SUM_W = 35;

  localparam int CENTRE_WEIGHT = 8;

  // result queue, power of two so the pointers wrap by themselves
  localparam int QDEPTH       = 8;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QLVL_W       = $clog2(QDEPTH + 1);
  localparam int RES_PER_ITEM = 2;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(4096);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(4096);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ABS_MODE     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    OP_PIX,
    OP_FLUSH,
    OP_FETCH
  } op_t;

  typedef struct packed {
    item_kind_t       kind;
    logic [PIX_W-1:0] pixel;
  } src_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic [SUM_W-1:0]        abs_sum;
    logic                    frame_end;
  } res_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pix_col_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } q_entry_t;

  typedef struct packed {
    logic     push0;
    logic     push1;
    q_entry_t e0;
    q_entry_t e1;
  } q_push_t;

  // centre weighted against the eight surrounding pixels
  function automatic logic signed [VAL_W-1:0] lap(pix_col_t l, pix_col_t c, pix_col_t r);
    logic [VAL_W-1:0] ring;
    logic [VAL_W-1:0] centre;
    ring = VAL_W'(l.top) + VAL_W'(l.mid) + VAL_W'(l.bot) + VAL_W'(c.top)
         + VAL_W'(c.bot) + VAL_W'(r.top) + VAL_W'(r.mid) + VAL_W'(r.bot);
    centre = VAL_W'(CENTRE_WEIGHT * int'(c.mid));
    return $signed(centre - ring);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lf3_ram.sv @@
`default_nettype none

module lf3_ram import lf3_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int WIDTH = PIX_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ hw/rtl/lf3_result_q.sv @@
`default_nettype none

module lf3_result_q import lf3_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              abs_mode,
  input  wire q_push_t           push,
  output logic      [QLVL_W-1:0] level,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output res_item_t              res_item
);

  q_entry_t q [QDEPTH];

  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] wr_ptr1;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QLVL_W-1:0] level_next;
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  acc_sum;
  logic [VAL_W-1:0]  mag;
  logic              load;
  q_entry_t          head;

  assign wr_ptr1 = wr_ptr + 1'b1;
  assign head    = q[rd_ptr];
  assign load    = (level != '0) && (!res_valid || !res_stall);
  assign mag     = head.value[VAL_W-1] ? (~head.value + 1'b1) : head.value;
  assign acc_sum = acc + SUM_W'(mag);

  assign level_next = level + QLVL_W'(push.push0) + QLVL_W'(push.push1)
                    - QLVL_W'(load);

  always_ff @(posedge clk) begin
    if (push.push0) begin
      q[wr_ptr] <= push.e0;
    end
    if (push.push1) begin
      q[wr_ptr1] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      level     <= '0;
      acc       <= '0;
      res_valid <= 1'b0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.push0) + QPTR_W'(push.push1);
      level  <= level_next;
      if (load) begin
        rd_ptr    <= rd_ptr + 1'b1;
        res_valid <= 1'b1;
        // running sum restarts after the last result of a frame
        acc       <= head.last ? '0 : acc_sum;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_item.value     <= abs_mode ? $signed(mag) : head.value;
      res_item.out_row   <= head.row;
      res_item.out_col   <= head.col;
      res_item.abs_sum   <= acc_sum;
      res_item.frame_end <= head.last;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/laplace_filter_3x3.sv @@
// channel  | signals                           | transfer when
// ---------+-----------------------------------+---------------------------------
// src      | src_valid, src_stall, src_item    | src_valid && !src_stall
// res      | res_valid, res_stall, res_item    | res_valid && !res_stall
// cfg      | cfg_we, cfg_addr, cfg_wdata       | cfg_we
//
// One item per clock while src_stall is low; the line buffers are read at the
// transfer edge and written back in the next cycle. An item's results pass the
// stage B register, the result queue and the output register, the second behind
// the first. A flush arriving right behind the last pixel of a frame waits for
// the line buffer write; a flush whose left column is not held costs an extra read.
// Up to two results per item, one per clock out of an 8-entry queue unless stalled.
// Synchronous reset clears counters and control; line buffers are not cleared.
// src_stall rises when the queue might not hold the results still in flight.
`default_nettype none

module laplace_filter_3x3 import lf3_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_addr,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             src_valid,
  output logic                  src_stall,
  input  wire src_item_t        src_item,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output res_item_t             res_item
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] px;
    logic [CW-1:0]    col;
    logic             first_col;
    logic             top_rep;
    logic             emit;
    logic             row_end;
    logic             last;
    logic             k_zero;
    logic [POS_W-1:0] row_out;
  } s1_t;

  // configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             abs_mode;
  logic [CW-1:0]    w_last;
  logic [RW-1:0]    h_eff;

  // position counters
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] flush_count;

  // flush column held from the previous read
  logic             h_valid;
  logic [CW-1:0]    h_tag;
  logic [PIX_W-1:0] hold_ab;
  logic [PIX_W-1:0] hold_tw;

  // stage A decode
  logic          flushing;
  logic          pix_end;
  logic [CW-1:0] k;
  logic [CW-1:0] kl;
  logic [CW-1:0] kr;
  logic          k_zero;
  logic          k_last;
  logic          hit;
  logic          miss;
  logic          flush_rd;
  logic          hazard;
  logic          room_ok;
  logic          need_fetch;
  logic          accept;
  logic          acc_pix;
  logic          acc_flush;
  logic          fetch_go;
  logic [CW-1:0] rd_a;
  logic [CW-1:0] rd_b;

  // stage B
  logic             s1_valid;
  s1_t              s1;
  s1_t              s1_next;
  logic             is_pix;
  logic             is_flush;
  logic             pix_emit;
  logic [PIX_W-1:0] rd_ab_a;
  logic [PIX_W-1:0] rd_ab_b;
  logic [PIX_W-1:0] rd_tw_a;
  logic [PIX_W-1:0] rd_tw_b;
  pix_col_t         nc;
  pix_col_t         win_cur;
  pix_col_t         win_prev;
  pix_col_t         l_col;
  pix_col_t         c_col;
  pix_col_t         r_col;
  q_push_t          q_push;
  logic [QLVL_W-1:0] q_level;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      abs_mode     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:  frame_width  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata;
        REG_ABS_MODE:     abs_mode     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < CFG_W'(2)) begin
      w_last = CW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(frame_width - 1'b1);
    end
    if (frame_height == '0) begin
      h_eff = RW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(frame_height);
    end
  end

  // stage A: decode, counters, line buffer read addresses
  always_comb begin
    flushing = row_count >= h_eff;
    pix_end  = col_count >= w_last;
    k        = (flush_count > w_last) ? w_last : flush_count;
    k_zero   = k == '0;
    k_last   = k == w_last;
    kl       = k_zero ? '0 : k - 1'b1;
    kr       = k_last ? k : k + 1'b1;
    hit      = h_valid && (h_tag == kl);
    miss     = !k_zero && !hit;

    flush_rd   = flushing && (src_item.kind == KIND_FLUSH);
    // a flush read must not meet the pending write of the last pixel
    hazard     = s1_valid && (s1.op == OP_PIX) && flush_rd;
    room_ok    = (32'(q_level) + (s1_valid ? 32'(RES_PER_ITEM) : 32'd0)
                 + 32'(RES_PER_ITEM)) <= 32'(QDEPTH);
    need_fetch = flush_rd && miss;
    src_stall  = !room_ok || hazard || need_fetch;

    accept    = src_valid && !src_stall;
    acc_pix   = accept && !flushing && (src_item.kind == KIND_PIXEL);
    acc_flush = accept && flush_rd;
    fetch_go  = src_valid && need_fetch && room_ok && !hazard;

    rd_a = flushing ? (need_fetch ? kl : k) : col_count;
    rd_b = kr;
  end

  always_comb begin
    s1_next.op        = acc_pix ? OP_PIX : (acc_flush ? OP_FLUSH : OP_FETCH);
    s1_next.px        = src_item.pixel;
    s1_next.col       = acc_pix ? col_count : k;
    s1_next.first_col = col_count == '0;
    s1_next.top_rep   = row_count <= RW'(1);
    s1_next.emit      = row_count != '0;
    s1_next.row_end   = pix_end;
    s1_next.last      = k_last;
    s1_next.k_zero    = k_zero;
    s1_next.row_out   = acc_pix ? POS_W'(row_count - 1'b1) : POS_W'(h_eff - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      flush_count <= '0;
      h_valid     <= 1'b0;
      h_tag       <= '0;
      s1_valid    <= 1'b0;
    end else begin
      s1_valid <= acc_pix || acc_flush || fetch_go;
      if (acc_pix) begin
        h_valid <= 1'b0;
        if (pix_end) begin
          col_count <= '0;
          row_count <= row_count + 1'b1;
        end else begin
          col_count <= col_count + 1'b1;
        end
      end else if (acc_flush) begin
        h_valid <= 1'b1;
        h_tag   <= k;
        if (k_last) begin
          col_count   <= '0;
          row_count   <= '0;
          flush_count <= '0;
        end else begin
          flush_count <= k + 1'b1;
        end
      end else if (fetch_go) begin
        h_valid <= 1'b1;
        h_tag   <= kl;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
  end

  lf3_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PIX_W)
  ) u_row_above (
    .clk     (clk),
    .we      (is_pix),
    .waddr   (s1.col),
    .wdata   (s1.px),
    .raddr_a (rd_a),
    .raddr_b (rd_b),
    .rdata_a (rd_ab_a),
    .rdata_b (rd_ab_b)
  );

  lf3_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PIX_W)
  ) u_row_two_above (
    .clk     (clk),
    .we      (is_pix),
    .waddr   (s1.col),
    .wdata   (rd_ab_a),
    .raddr_a (rd_a),
    .raddr_b (rd_b),
    .rdata_a (rd_tw_a),
    .rdata_b (rd_tw_b)
  );

  // stage B: read-modify-write of the line buffers and the kernel
  always_comb begin
    is_pix   = s1_valid && (s1.op == OP_PIX);
    is_flush = s1_valid && (s1.op == OP_FLUSH);
    pix_emit = is_pix && !s1.first_col && s1.emit;

    nc.top = s1.top_rep ? rd_ab_a : rd_tw_a;
    nc.mid = rd_ab_a;
    nc.bot = s1.px;

    // last row is replicated downward
    c_col.top = s1.top_rep ? rd_ab_a : rd_tw_a;
    c_col.mid = rd_ab_a;
    c_col.bot = rd_ab_a;
    r_col.top = s1.top_rep ? rd_ab_b : rd_tw_b;
    r_col.mid = rd_ab_b;
    r_col.bot = rd_ab_b;
    if (s1.k_zero) begin
      l_col = c_col;
    end else begin
      l_col.top = s1.top_rep ? hold_ab : hold_tw;
      l_col.mid = hold_ab;
      l_col.bot = hold_ab;
    end

    q_push.push0 = pix_emit || is_flush;
    q_push.push1 = pix_emit && s1.row_end;
    q_push.e0.row = s1.row_out;
    q_push.e1.row = s1.row_out;
    if (is_flush) begin
      q_push.e0.value = lap(l_col, c_col, r_col);
      q_push.e0.col   = POS_W'(s1.col);
      q_push.e0.last  = s1.last;
    end else begin
      q_push.e0.value = lap(win_prev, win_cur, nc);
      q_push.e0.col   = POS_W'(s1.col - 1'b1);
      q_push.e0.last  = 1'b0;
    end
    // right edge column replicated
    q_push.e1.value = lap(win_cur, nc, nc);
    q_push.e1.col   = POS_W'(s1.col);
    q_push.e1.last  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (is_pix) begin
      if (s1.first_col) begin
        win_prev <= nc;
      end else begin
        win_prev <= win_cur;
      end
      win_cur <= nc;
    end
    if (s1_valid && (s1.op != OP_PIX)) begin
      hold_ab <= rd_ab_a;
      hold_tw <= rd_tw_a;
    end
  end

  lf3_result_q u_result_q (
    .clk       (clk),
    .rst       (rst),
    .abs_mode  (abs_mode),
    .push      (q_push),
    .level     (q_level),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  a_no_read_over_write: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1.op == OP_PIX)) |-> !(acc_flush || fetch_go))
    else $error("flush read issued while a line buffer write is pending");

  a_left_col_held: assert property (@(posedge clk) disable iff (rst)
    (acc_flush && !k_zero) |-> (h_valid && (h_tag == kl)))
    else $error("flush accepted without its left column held");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    $past(accept) |-> (32'(q_level) <= 32'(QDEPTH)))
    else $error("result queue overrun");

endmodule

`default_nettype wire
